// File: rtl/core/bsd_pkg.sv
// bsd_pkg: shared types and constants of the BMP stream decoder.
// No dependencies; used by every module under rtl/core.
package bsd_pkg;

  localparam int MAX_WIDTH_DEF      = 2048;
  localparam int MAX_HEIGHT_DEF     = 2048;
  localparam int MAX_FILE_BYTES_DEF = 4194304;

  localparam int POS_W   = 23;
  localparam int LEN_W   = 23;
  localparam int IDX_W   = 22;
  localparam int DIM_O_W = 12;
  localparam int NEED_W  = 33;

  localparam logic [POS_W-1:0] POS_MAX      = {POS_W{1'b1}};
  localparam logic [POS_W-1:0] POS_SIG_LO   = 23'd0;
  localparam logic [POS_W-1:0] POS_SIG_HI   = 23'd1;
  localparam logic [POS_W-1:0] POS_OFS_LO   = 23'd10;
  localparam logic [POS_W-1:0] POS_OFS_HI   = 23'd13;
  localparam logic [POS_W-1:0] POS_DIB_LO   = 23'd14;
  localparam logic [POS_W-1:0] POS_DIB_HI   = 23'd17;
  localparam logic [POS_W-1:0] POS_WID_LO   = 23'd18;
  localparam logic [POS_W-1:0] POS_WID_HI   = 23'd21;
  localparam logic [POS_W-1:0] POS_HGT_LO   = 23'd22;
  localparam logic [POS_W-1:0] POS_HGT_HI   = 23'd25;
  localparam logic [POS_W-1:0] POS_STRIDE   = 23'd26;
  localparam logic [POS_W-1:0] POS_PROD     = 23'd27;
  localparam logic [POS_W-1:0] POS_BPP_LO   = 23'd28;
  localparam logic [POS_W-1:0] POS_BPP_HI   = 23'd29;

  localparam logic [LEN_W-1:0] MIN_FILE_LEN = 23'd54;
  localparam logic [7:0]       SIG_B        = 8'h42;
  localparam logic [7:0]       SIG_M        = 8'h4D;
  localparam logic [31:0]      MIN_OFFSET   = 32'd30;
  localparam logic [31:0]      MIN_DIB      = 32'd40;
  localparam logic [15:0]      DEPTH_24     = 16'd24;
  localparam logic [15:0]      DEPTH_32     = 16'd32;
  localparam logic [7:0]       ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_SKIP   = 2'd1,
    PH_PIXELS = 2'd2,
    PH_IDLE   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_SIG      = 4'd2,
    ST_OFFSET   = 4'd3,
    ST_DIB      = 4'd4,
    ST_BPP      = 4'd5,
    ST_WIDTH    = 4'd6,
    ST_HEIGHT   = 4'd7,
    ST_DATA     = 4'd8,
    ST_OFS_HDR  = 4'd9
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_PIXEL  = 1'b1
  } kind_t;

  typedef struct packed {
    logic    done;
    logic    ok;
    status_t code;
  } hdr_evt_t;

  typedef struct packed {
    logic emit;
    logic last;
    logic finish;
  } pix_evt_t;

endpackage

// File: rtl/core/bsd_in_if.sv
// bsd_in_if: byte request channel of the BMP stream decoder.
// Carries valid/ready and one file byte with its start mark.
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;

  modport source (output valid, output data_byte, output start_of_file, input ready);
  modport sink   (input valid, input data_byte, input start_of_file, output ready);
endinterface

// File: rtl/core/bsd_out_if.sv
// bsd_out_if: result request channel of the BMP stream decoder.
// Carries valid/ready and one status or pixel result.
interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [3:0]  status_code;
  logic [11:0] image_width;
  logic [11:0] image_height;
  logic [31:0] pixel_argb;
  logic [21:0] pixel_index;
  logic        last_pixel;

  modport source (output valid, output result_kind, output status_code, output image_width,
                  output image_height, output pixel_argb, output pixel_index,
                  output last_pixel, input ready);
  modport sink   (input valid, input result_kind, input status_code, input image_width,
                  input image_height, input pixel_argb, input pixel_index,
                  input last_pixel, output ready);
endinterface

// File: rtl/core/bsd_header.sv
// bsd_header: captures the little-endian header fields and runs the header checks.
// Depends on bsd_pkg.
module bsd_header #(
  parameter int MAX_WIDTH  = bsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bsd_pkg::MAX_HEIGHT_DEF,
  parameter int COL_W      = $clog2(MAX_WIDTH + 1),
  parameter int ROW_W      = $clog2(MAX_HEIGHT + 1),
  parameter int RB_W       = COL_W + 2
) (
  input  logic                        clk,
  input  logic                        in_fire,
  input  logic                        hdr_phase,
  input  logic [7:0]                  in_byte,
  input  logic [bsd_pkg::POS_W-1:0]   pos,
  input  logic [bsd_pkg::LEN_W-1:0]   file_size,
  output bsd_pkg::hdr_evt_t           evt,
  output logic [31:0]                 offset,
  output logic [COL_W-1:0]            w_dim,
  output logic [ROW_W-1:0]            h_dim,
  output logic [RB_W-1:0]             stride,
  output logic                        depth_is32,
  output logic [bsd_pkg::IDX_W-1:0]   row_base
);
  import bsd_pkg::*;

  localparam int PROD_W = COL_W + ROW_W + 2;

  logic [15:0]       sig_r, sig_nxt;
  logic [31:0]       ofs_r, ofs_nxt;
  logic [31:0]       dib_r, dib_nxt;
  logic [31:0]       wid_r, wid_nxt;
  logic [31:0]       hgt_r, hgt_nxt;
  logic [15:0]       dep_r, dep_nxt;
  logic [RB_W-1:0]   stride3_r;
  logic [COL_W+ROW_W-1:0] wh_r;
  logic [PROD_W-1:0] s3h_r;

  logic [1:0]        lane;
  logic              wr;
  logic [15:0]       dep_cur;
  logic              dep32_cur;
  logic [NEED_W-1:0] need;
  logic [31:0]       rb_full;
  status_t           code;

  assign lane  = pos[1:0] - 2'd2;
  assign wr    = in_fire && hdr_phase;
  assign w_dim = wid_r[COL_W-1:0];
  assign h_dim = hgt_r[ROW_W-1:0];

  always_comb begin
    sig_nxt = sig_r;
    ofs_nxt = ofs_r;
    dib_nxt = dib_r;
    wid_nxt = wid_r;
    hgt_nxt = hgt_r;
    dep_nxt = dep_r;
    if (wr) begin
      if (pos == POS_SIG_LO) begin
        sig_nxt[7:0] = in_byte;
      end else if (pos == POS_SIG_HI) begin
        sig_nxt[15:8] = in_byte;
      end else if (pos >= POS_OFS_LO && pos <= POS_OFS_HI) begin
        ofs_nxt[8*lane +: 8] = in_byte;
      end else if (pos >= POS_DIB_LO && pos <= POS_DIB_HI) begin
        dib_nxt[8*lane +: 8] = in_byte;
      end else if (pos >= POS_WID_LO && pos <= POS_WID_HI) begin
        wid_nxt[8*lane +: 8] = in_byte;
      end else if (pos >= POS_HGT_LO && pos <= POS_HGT_HI) begin
        hgt_nxt[8*lane +: 8] = in_byte;
      end else if (pos == POS_BPP_LO) begin
        dep_nxt[7:0] = in_byte;
      end else if (pos == POS_BPP_HI) begin
        dep_nxt[15:8] = in_byte;
      end
    end
  end

  // size products are formed ahead of the last header byte
  always_ff @(posedge clk) begin
    sig_r <= sig_nxt;
    ofs_r <= ofs_nxt;
    dib_r <= dib_nxt;
    wid_r <= wid_nxt;
    hgt_r <= hgt_nxt;
    dep_r <= dep_nxt;
    if (wr && pos == POS_STRIDE) begin
      stride3_r <= (RB_W'({2'b00, w_dim}) * RB_W'(3) + RB_W'(3)) & ~RB_W'(3);
      wh_r      <= (COL_W+ROW_W)'(w_dim) * (COL_W+ROW_W)'(h_dim);
    end
    if (wr && pos == POS_PROD) begin
      s3h_r <= PROD_W'(stride3_r) * PROD_W'(h_dim);
    end
  end

  assign dep_cur   = {in_byte, dep_r[7:0]};
  assign dep32_cur = (dep_cur == DEPTH_32);
  assign need      = NEED_W'(ofs_r) +
                     (dep32_cur ? NEED_W'({wh_r, 2'b00}) : NEED_W'(s3h_r));

  always_comb begin
    if (file_size < MIN_FILE_LEN) begin
      code = ST_SHORT;
    end else if (sig_r[7:0] != SIG_B || sig_r[15:8] != SIG_M) begin
      code = ST_SIG;
    end else if (ofs_r >= 32'(file_size)) begin
      code = ST_OFFSET;
    end else if (ofs_r < MIN_OFFSET) begin
      code = ST_OFS_HDR;
    end else if (dib_r < MIN_DIB) begin
      code = ST_DIB;
    end else if (dep_cur != DEPTH_24 && dep_cur != DEPTH_32) begin
      code = ST_BPP;
    end else if (wid_r == 32'd0 || wid_r > 32'(MAX_WIDTH)) begin
      code = ST_WIDTH;
    end else if (hgt_r == 32'd0 || hgt_r > 32'(MAX_HEIGHT)) begin
      code = ST_HEIGHT;
    end else if (need > NEED_W'(file_size)) begin
      code = ST_DATA;
    end else begin
      code = ST_OK;
    end
  end

  assign evt.done = wr && pos == POS_BPP_HI;
  assign evt.ok   = (code == ST_OK);
  assign evt.code = code;

  assign rb_full    = 32'(wh_r) - 32'(w_dim);
  assign row_base   = rb_full[IDX_W-1:0];
  assign offset     = ofs_r;
  assign depth_is32 = (dep_r == DEPTH_32);
  assign stride     = depth_is32 ? {w_dim, 2'b00} : stride3_r;

endmodule

// File: rtl/core/bsd_pixel.sv
// bsd_pixel: row, column and byte counters that pack B,G,R into ARGB pixels.
// Depends on bsd_pkg.
module bsd_pixel #(
  parameter int MAX_WIDTH  = bsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bsd_pkg::MAX_HEIGHT_DEF,
  parameter int COL_W      = $clog2(MAX_WIDTH + 1),
  parameter int ROW_W      = $clog2(MAX_HEIGHT + 1),
  parameter int RB_W       = COL_W + 2
) (
  input  logic                      clk,
  input  logic                      go,
  input  logic                      load,
  input  logic [7:0]                in_byte,
  input  logic [COL_W-1:0]          w_dim,
  input  logic [ROW_W-1:0]          h_dim,
  input  logic [RB_W-1:0]           stride,
  input  logic                      depth_is32,
  input  logic [bsd_pkg::IDX_W-1:0] row_base,
  output bsd_pkg::pix_evt_t         evt,
  output logic [31:0]               argb,
  output logic [bsd_pkg::IDX_W-1:0] index
);
  import bsd_pkg::*;

  logic [RB_W-1:0]  rbytes_r, rbytes_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [1:0]       within_r, within_nxt;
  logic [15:0]      hold_r, hold_nxt;
  logic [IDX_W-1:0] base_r, base_nxt;

  logic [1:0] bpp_m1;
  logic       in_row;
  logic       col_last;
  logic       row_last;
  logic       row_end;

  assign bpp_m1   = depth_is32 ? 2'd3 : 2'd2;
  assign in_row   = col_r < w_dim;
  assign col_last = ((COL_W+1)'(col_r) + 1'b1) == (COL_W+1)'(w_dim);
  assign row_last = ((ROW_W+1)'(row_r) + 1'b1) == (ROW_W+1)'(h_dim);
  assign row_end  = ((RB_W+1)'(rbytes_r) + 1'b1) == (RB_W+1)'(stride);

  assign argb  = {ALPHA_OPAQUE, in_byte, hold_r[15:8], hold_r[7:0]};
  assign index = base_r + IDX_W'(col_r);

  always_comb begin
    rbytes_nxt = rbytes_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    within_nxt = within_r;
    hold_nxt   = hold_r;
    base_nxt   = base_r;
    evt        = '0;
    if (load) begin
      rbytes_nxt = '0;
      col_nxt    = '0;
      row_nxt    = '0;
      within_nxt = '0;
      hold_nxt   = '0;
      base_nxt   = row_base;
    end else if (go) begin
      if (in_row) begin
        case (within_r)
          2'd0:    hold_nxt = {8'h00, in_byte};
          2'd1:    hold_nxt[15:8] = in_byte;
          2'd2: begin
            evt.emit = 1'b1;
            evt.last = row_last && col_last;
          end
          default: hold_nxt = hold_r;
        endcase
        if (within_r == bpp_m1) begin
          within_nxt = '0;
          col_nxt    = col_r + 1'b1;
        end else begin
          within_nxt = within_r + 1'b1;
        end
      end
      if (!evt.last) begin
        rbytes_nxt = rbytes_r + 1'b1;
        if (row_end) begin
          rbytes_nxt = '0;
          col_nxt    = '0;
          within_nxt = '0;
          row_nxt    = row_r + 1'b1;
          base_nxt   = base_r - IDX_W'(w_dim);
          evt.finish = row_last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rbytes_r <= rbytes_nxt;
    col_r    <= col_nxt;
    row_r    <= row_nxt;
    within_r <= within_nxt;
    hold_r   <= hold_nxt;
    base_r   <= base_nxt;
  end

endmodule

// File: rtl/core/bmp_stream_decoder.sv
// bmp_stream_decoder: streaming decoder for uncompressed 24/32-bit BMP files.
// Depends on bsd_pkg, bsd_in_if, bsd_out_if, bsd_header and bsd_pixel.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        data_byte, start_of_file
//   out_ch   out  valid/ready        status or pixel result
//   cfg      in   cfg_wr_en          cfg_wr_data (file length)
//
// One byte per cycle; a byte's result is registered and shows in the cycle after it is taken.
// The output register is refilled in the cycle it drains, so stalls only when
// out_ch.ready is low with a result held. Synchronous active-low reset; no
// clearing pass. Width/height products are formed on header bytes 26 and 27.
module bmp_stream_decoder #(
  parameter int MAX_WIDTH      = bsd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT     = bsd_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_FILE_BYTES = bsd_pkg::MAX_FILE_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bsd_pkg::LEN_W-1:0] cfg_wr_data,
  bsd_in_if.sink                    in_ch,
  bsd_out_if.source                 out_ch
);
  import bsd_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W = $clog2(MAX_HEIGHT + 1);
  localparam int RB_W  = COL_W + 2;

  logic [LEN_W-1:0] file_size_r;
  logic [POS_W-1:0] pos_r, pos_nxt, pos_e;
  phase_t           phase_r, phase_nxt, phase_e;

  logic in_ready, in_fire, start;
  logic skip_hit, pix_go, pix_end;

  hdr_evt_t         hdr_evt;
  pix_evt_t         pix_evt;
  logic [31:0]      offset;
  logic [COL_W-1:0] w_dim;
  logic [ROW_W-1:0] h_dim;
  logic [RB_W-1:0]  stride;
  logic             depth_is32;
  logic [IDX_W-1:0] row_base;
  logic [31:0]      pix_argb;
  logic [IDX_W-1:0] pix_index;

  logic               res_valid;
  kind_t              res_kind;
  status_t            res_code;
  logic [DIM_O_W-1:0] res_w, res_h;
  logic [31:0]        res_argb;
  logic [IDX_W-1:0]   res_index;
  logic               res_last;

  logic               out_valid_r;
  kind_t              out_kind_r;
  status_t            out_code_r;
  logic [DIM_O_W-1:0] out_w_r, out_h_r;
  logic [31:0]        out_argb_r;
  logic [IDX_W-1:0]   out_index_r;
  logic               out_last_r;

  assign in_ready    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = in_ready;
  assign in_fire     = in_ch.valid && in_ready;
  assign start       = in_ch.start_of_file;

  // start mark restarts with this byte as byte zero
  assign pos_e   = start ? '0 : pos_r;
  assign phase_e = start ? PH_HEADER : phase_r;
  assign pos_nxt = (pos_e == POS_MAX) ? pos_e : pos_e + 1'b1;

  assign skip_hit = (phase_e == PH_SKIP) && (offset[31:POS_W] == '0) &&
                    (offset[POS_W-1:0] == pos_e);
  assign pix_go   = in_fire && ((phase_e == PH_PIXELS) || skip_hit);
  assign pix_end  = pix_evt.last || pix_evt.finish;

  bsd_header #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W),
    .RB_W       (RB_W)
  ) u_header (
    .clk        (clk),
    .in_fire    (in_fire),
    .hdr_phase  (phase_e == PH_HEADER),
    .in_byte    (in_ch.data_byte),
    .pos        (pos_e),
    .file_size  (file_size_r),
    .evt        (hdr_evt),
    .offset     (offset),
    .w_dim      (w_dim),
    .h_dim      (h_dim),
    .stride     (stride),
    .depth_is32 (depth_is32),
    .row_base   (row_base)
  );

  bsd_pixel #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .COL_W      (COL_W),
    .ROW_W      (ROW_W),
    .RB_W       (RB_W)
  ) u_pixel (
    .clk        (clk),
    .go         (pix_go),
    .load       (hdr_evt.done && hdr_evt.ok),
    .in_byte    (in_ch.data_byte),
    .w_dim      (w_dim),
    .h_dim      (h_dim),
    .stride     (stride),
    .depth_is32 (depth_is32),
    .row_base   (row_base),
    .evt        (pix_evt),
    .argb       (pix_argb),
    .index      (pix_index)
  );

  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_e)
        PH_HEADER: begin
          if (hdr_evt.done) begin
            phase_nxt = hdr_evt.ok ? PH_SKIP : PH_IDLE;
          end else begin
            phase_nxt = PH_HEADER;
          end
        end
        PH_SKIP: begin
          if (skip_hit) begin
            phase_nxt = pix_end ? PH_IDLE : PH_PIXELS;
          end
        end
        PH_PIXELS: begin
          if (pix_end) begin
            phase_nxt = PH_IDLE;
          end
        end
        PH_IDLE:  phase_nxt = PH_IDLE;
        default:  phase_nxt = phase_e;
      endcase
    end
  end

  always_comb begin
    res_valid = 1'b0;
    res_kind  = KIND_STATUS;
    res_code  = ST_OK;
    res_w     = '0;
    res_h     = '0;
    res_argb  = '0;
    res_index = '0;
    res_last  = 1'b0;
    if (in_fire && hdr_evt.done) begin
      res_valid = 1'b1;
      res_code  = hdr_evt.code;
      if (hdr_evt.ok) begin
        res_w = DIM_O_W'(w_dim);
        res_h = DIM_O_W'(h_dim);
      end
    end else if (pix_go && pix_evt.emit) begin
      res_valid = 1'b1;
      res_kind  = KIND_PIXEL;
      res_argb  = pix_argb;
      res_index = pix_index;
      res_last  = pix_evt.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      file_size_r <= '0;
      pos_r       <= '0;
      phase_r     <= PH_HEADER;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        file_size_r <= (32'(cfg_wr_data) > 32'(MAX_FILE_BYTES)) ?
                       LEN_W'(MAX_FILE_BYTES) : cfg_wr_data;
      end
      if (in_fire) begin
        pos_r <= pos_nxt;
      end
      phase_r <= phase_nxt;
      if (in_ready) begin
        out_valid_r <= in_fire && res_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_kind_r  <= res_kind;
      out_code_r  <= res_code;
      out_w_r     <= res_w;
      out_h_r     <= res_h;
      out_argb_r  <= res_argb;
      out_index_r <= res_index;
      out_last_r  <= res_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_kind  = out_kind_r;
  assign out_ch.status_code  = out_code_r;
  assign out_ch.image_width  = out_w_r;
  assign out_ch.image_height = out_h_r;
  assign out_ch.pixel_argb   = out_argb_r;
  assign out_ch.pixel_index  = out_index_r;
  assign out_ch.last_pixel   = out_last_r;

endmodule
